### src/wsfs_pkg.sv
// wsfs_pkg: shared types and constants of the ws2812 frame serializer
`default_nettype none
package wsfs_pkg;

    localparam int CMD_W    = 2;
    localparam int FIRST_W  = 6;
    localparam int END_W    = 7;
    localparam int COLOR_W  = 8;
    localparam int PIXEL_W  = 24;
    localparam int BITIDX_W = 5;
    localparam int COUNT_W  = 7;
    localparam int TIMER_W  = 16;
    localparam int CFGIDX_W = 3;
    localparam int CFGDAT_W = 16;

    typedef logic [PIXEL_W-1:0] grb_t;

    localparam logic [CMD_W-1:0] CMD_FILL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SHOW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [CFGIDX_W-1:0] CFG_PIXEL_COUNT  = 3'd0;
    localparam logic [CFGIDX_W-1:0] CFG_BIT_PERIOD   = 3'd1;
    localparam logic [CFGIDX_W-1:0] CFG_RESET_PERIOD = 3'd2;
    localparam logic [CFGIDX_W-1:0] CFG_ONE_HIGH     = 3'd3;
    localparam logic [CFGIDX_W-1:0] CFG_ZERO_HIGH    = 3'd4;

    localparam logic [COUNT_W-1:0] RST_PIXEL_COUNT  = 7'd39;
    localparam logic [TIMER_W-1:0] RST_BIT_PERIOD   = 16'd700;
    localparam logic [TIMER_W-1:0] RST_RESET_PERIOD = 16'd6000;
    localparam logic [TIMER_W-1:0] RST_ONE_HIGH     = 16'd57;
    localparam logic [TIMER_W-1:0] RST_ZERO_HIGH    = 16'd27;

    localparam logic [BITIDX_W-1:0] BIT_LAST = 5'd23;

endpackage
`default_nettype wire

### src/wsfs_ram.sv
// wsfs_ram: generic single-write, single-read ram with registered read data
`default_nettype none
module wsfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/ws2812_frame_serializer.sv
// ws2812_frame_serializer: pixel store and per-bit pwm compare sequencer
//
// Holds one GRB colour per pixel in a ram and turns a frame into one pwm
// compare value and timer period per timer tick. After reset a clearing pass
// writes zero to every pixel, one entry per cycle; no beat is taken meanwhile,
// configuration writes are. A fill beat writes its pixels in turn through the
// single ram write port. Show and the first tick after it answer in the next
// cycle; a data tick first passes through the bit state, for the registered
// ram read. A new beat is taken only once the sequencer is back in idle and
// the previous result beat has been taken.
`default_nettype none
module ws2812_frame_serializer #(
    parameter int MAX_PIXELS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic [wsfs_pkg::CFGIDX_W-1:0]       cfg_index,
    input  wire logic [wsfs_pkg::CFGDAT_W-1:0]       cfg_data,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [wsfs_pkg::CMD_W-1:0]          cmd,
    input  wire logic [wsfs_pkg::FIRST_W-1:0]        first_pixel,
    input  wire logic [wsfs_pkg::END_W-1:0]          end_pixel,
    input  wire logic [wsfs_pkg::COLOR_W-1:0]        red,
    input  wire logic [wsfs_pkg::COLOR_W-1:0]        green,
    input  wire logic [wsfs_pkg::COLOR_W-1:0]        blue,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [wsfs_pkg::TIMER_W-1:0]        duty,
    output logic      [wsfs_pkg::TIMER_W-1:0]        period,
    output logic                                     frame_done
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int CW = (PW > wsfs_pkg::END_W) ? PW : wsfs_pkg::END_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_PIXELS);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_PIXELS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_BIT   = 3'd3;

    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   fill_idx_reg, fill_idx_next;
    logic [CW-1:0]                   fill_end_reg, fill_end_next;
    wsfs_pkg::grb_t                  grb_reg, grb_next;

    logic                            sending_reg, sending_next;
    logic                            gap_reg, gap_next;
    logic [CW-1:0]                   pixel_index_reg, pixel_index_next;
    logic [wsfs_pkg::BITIDX_W-1:0]   bit_index_reg, bit_index_next;

    logic [wsfs_pkg::COUNT_W-1:0]    pixel_count_reg;
    logic [wsfs_pkg::TIMER_W-1:0]    bit_period_reg;
    logic [wsfs_pkg::TIMER_W-1:0]    reset_period_reg;
    logic [wsfs_pkg::TIMER_W-1:0]    one_high_reg;
    logic [wsfs_pkg::TIMER_W-1:0]    zero_high_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [wsfs_pkg::TIMER_W-1:0]    duty_reg, duty_next;
    logic [wsfs_pkg::TIMER_W-1:0]    period_reg, period_next;
    logic                            frame_done_reg, frame_done_next;

    logic                            accept;
    logic [CW-1:0]                   count_ext;
    logic [CW-1:0]                   eff_count;
    logic [CW-1:0]                   end_clamp;
    logic [CW-1:0]                   first_ext;
    logic [CW-1:0]                   end_ext;
    logic                            ram_we;
    wsfs_pkg::grb_t                  ram_wdata;
    wsfs_pkg::grb_t                  ram_rdata;
    logic                            data_bit;

    wsfs_ram #(
        .WIDTH (wsfs_pkg::PIXEL_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_idx_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (pixel_index_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // effective pixel count, clamped to the store and never zero
    always_comb
    begin
        count_ext = CW'(pixel_count_reg);
        eff_count = (count_ext > MAX_C) ? MAX_C : count_ext;
        if (eff_count == '0)
        begin
            eff_count = CW'(1);
        end
    end

    assign first_ext = CW'(first_pixel);
    assign end_ext   = CW'(end_pixel);
    assign end_clamp = (end_ext > eff_count) ? eff_count : end_ext;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : grb_reg;
    assign data_bit  = ram_rdata[wsfs_pkg::BIT_LAST - bit_index_reg];

    always_comb
    begin
        state_next       = state_reg;
        fill_idx_next    = fill_idx_reg;
        fill_end_next    = fill_end_reg;
        grb_next         = grb_reg;
        sending_next     = sending_reg;
        gap_next         = gap_reg;
        pixel_index_next = pixel_index_reg;
        bit_index_next   = bit_index_reg;
        out_valid_next   = out_valid_reg && out_stall;
        duty_next        = duty_reg;
        period_next      = period_reg;
        frame_done_next  = frame_done_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                fill_idx_next = fill_idx_reg + CW'(1);
                if (fill_idx_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                fill_idx_next = fill_idx_reg + CW'(1);
                if (fill_idx_next == fill_end_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BIT:
            begin
                out_valid_next  = 1'b1;
                duty_next       = data_bit ? one_high_reg : zero_high_reg;
                period_next     = bit_period_reg;
                frame_done_next = 1'b0;
                state_next      = ST_IDLE;
                if (bit_index_reg == wsfs_pkg::BIT_LAST)
                begin
                    bit_index_next   = '0;
                    pixel_index_next = pixel_index_reg + CW'(1);
                    if (pixel_index_next >= eff_count)
                    begin
                        frame_done_next  = 1'b1;
                        sending_next     = 1'b0;
                        pixel_index_next = '0;
                    end
                end
                else
                begin
                    bit_index_next = bit_index_reg + 5'd1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        wsfs_pkg::CMD_FILL:
                        begin
                            if (!sending_reg && (first_ext < end_clamp))
                            begin
                                fill_idx_next = first_ext;
                                fill_end_next = end_clamp;
                                grb_next      = {green, red, blue};
                                state_next    = ST_FILL;
                            end
                        end
                        wsfs_pkg::CMD_SHOW:
                        begin
                            if (!sending_reg)
                            begin
                                sending_next     = 1'b1;
                                gap_next         = 1'b1;
                                pixel_index_next = '0;
                                bit_index_next   = '0;
                                out_valid_next   = 1'b1;
                                duty_next        = '0;
                                period_next      = reset_period_reg;
                                frame_done_next  = 1'b0;
                            end
                        end
                        wsfs_pkg::CMD_TICK:
                        begin
                            if (sending_reg)
                            begin
                                if (gap_reg)
                                begin
                                    gap_next        = 1'b0;
                                    out_valid_next  = 1'b1;
                                    duty_next       = '0;
                                    period_next     = bit_period_reg;
                                    frame_done_next = 1'b0;
                                end
                                else
                                begin
                                    state_next = ST_BIT;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            fill_idx_reg    <= '0;
            fill_end_reg    <= '0;
            sending_reg     <= 1'b0;
            gap_reg         <= 1'b0;
            pixel_index_reg <= '0;
            bit_index_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_idx_reg    <= fill_idx_next;
            fill_end_reg    <= fill_end_next;
            sending_reg     <= sending_next;
            gap_reg         <= gap_next;
            pixel_index_reg <= pixel_index_next;
            bit_index_reg   <= bit_index_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grb_reg        <= grb_next;
        duty_reg       <= duty_next;
        period_reg     <= period_next;
        frame_done_reg <= frame_done_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg  <= wsfs_pkg::RST_PIXEL_COUNT;
            bit_period_reg   <= wsfs_pkg::RST_BIT_PERIOD;
            reset_period_reg <= wsfs_pkg::RST_RESET_PERIOD;
            one_high_reg     <= wsfs_pkg::RST_ONE_HIGH;
            zero_high_reg    <= wsfs_pkg::RST_ZERO_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsfs_pkg::CFG_PIXEL_COUNT:
                begin
                    pixel_count_reg <= cfg_data[wsfs_pkg::COUNT_W-1:0];
                end
                wsfs_pkg::CFG_BIT_PERIOD:
                begin
                    bit_period_reg <= cfg_data;
                end
                wsfs_pkg::CFG_RESET_PERIOD:
                begin
                    reset_period_reg <= cfg_data;
                end
                wsfs_pkg::CFG_ONE_HIGH:
                begin
                    one_high_reg <= cfg_data;
                end
                wsfs_pkg::CFG_ZERO_HIGH:
                begin
                    zero_high_reg <= cfg_data;
                end
                default:
                begin
                    pixel_count_reg <= pixel_count_reg;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty       = duty_reg;
    assign period     = period_reg;
    assign frame_done = frame_done_reg;

    // the bit state of a data tick always yields a result beat in the following cycle
    a_bit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BIT) |=> out_valid_reg)
        else $error("data tick gave no result beat");

    // a show while idle answers with a low gap beat
    a_show_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == wsfs_pkg::CMD_SHOW) && !sending_reg)
            |=> (out_valid_reg && (duty_reg == '0) && !frame_done_reg && sending_reg))
        else $error("show did not start a frame with a low gap");

    // read pointer stays inside the store while a frame is running
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> ((pixel_index_reg < MAX_C) && (bit_index_reg <= wsfs_pkg::BIT_LAST)))
        else $error("frame pointer out of range");

    // frame_done closes the frame
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BIT) && !sending_next) |=> (frame_done_reg && !sending_reg))
        else $error("frame end not flagged");

endmodule
`default_nettype wire
